>>> rtl/srit_pkg.sv
// ----------------------------------------------------------------------------
// srit_pkg: shared constants for the segment/rectangle hit test
// Coordinate width default and the number of rectangle edges.
// ----------------------------------------------------------------------------
package srit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int NUM_EDGES      = 4;

endpackage

>>> rtl/srit_edge.sv
// ----------------------------------------------------------------------------
// srit_edge: pipelined exact segment/segment intersection test
// Stage 1 forms differences, stage 2 the products, stage 3 the cross
// products and sign-normalized comparisons. Advances when i_en is high.
// ----------------------------------------------------------------------------
module srit_edge
    import srit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    output logic                         o_hit
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    // stage 1: differences
    logic signed [DW-1:0] r_ux, r_uy, r_vx, r_vy, r_wx, r_wy, r_n1x, r_n1y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ux  <= DW'(i_bx) - DW'(i_ax);
            r_uy  <= DW'(i_by) - DW'(i_ay);
            r_vx  <= DW'(i_qx) - DW'(i_px);
            r_vy  <= DW'(i_qy) - DW'(i_py);
            r_wx  <= DW'(i_ax) - DW'(i_px);
            r_wy  <= DW'(i_ay) - DW'(i_py);
            r_n1x <= DW'(i_bx) - DW'(i_px);
            r_n1y <= DW'(i_by) - DW'(i_py);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW-1:0] r2_ux, r2_uy, r2_vx, r2_vy, r2_wx, r2_wy, r2_n1x, r2_n1y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= PW'(r_ux) * PW'(r_vy);
            r_p1 <= PW'(r_uy) * PW'(r_vx);
            r_p2 <= PW'(r_ux) * PW'(r_wy);
            r_p3 <= PW'(r_uy) * PW'(r_wx);
            r_p4 <= PW'(r_vx) * PW'(r_wy);
            r_p5 <= PW'(r_vy) * PW'(r_wx);
            r2_ux <= r_ux; r2_uy <= r_uy; r2_vx <= r_vx; r2_vy <= r_vy;
            r2_wx <= r_wx; r2_wy <= r_wy; r2_n1x <= r_n1x; r2_n1y <= r_n1y;
        end
    end

    // stage 3: cross products and decision
    logic signed [CW-1:0] d, nu, nv, dn, nun, nvn;
    logic                 upt, vpt, col_hit, gen_hit, n_hit;
    logic signed [DW:0]   s, n0, n1, lo, hi;
    logic signed [DW:0]   pa, pb, pl, ph;

    always_comb begin
        d   = CW'(r_p0) - CW'(r_p1);
        nu  = CW'(r_p2) - CW'(r_p3);
        nv  = CW'(r_p4) - CW'(r_p5);
        upt = (r2_ux == '0) && (r2_uy == '0);
        vpt = (r2_vx == '0) && (r2_vy == '0);
        // point a relative to p is w; point p relative to a is -w
        if (r2_vx != '0) begin
            s = (DW+1)'(r2_vx); n0 = (DW+1)'(r2_wx); n1 = (DW+1)'(r2_n1x);
        end else begin
            s = (DW+1)'(r2_vy); n0 = (DW+1)'(r2_wy); n1 = (DW+1)'(r2_n1y);
        end
        if (s < 0) begin
            s = -s; n0 = -n0; n1 = -n1;
        end
        lo = (n0 < n1) ? n0 : n1;
        hi = (n0 < n1) ? n1 : n0;
        // on_seg of a point with one endpoint at origin: 0 and span between
        if (upt && vpt) begin
            pa = '0; pb = '0; pl = '0; ph = '0;
            col_hit = (r2_wx == '0) && (r2_wy == '0);
        end else if (upt) begin
            // a on p-q: w between 0 and v
            if (r2_vx != '0) begin pa = (DW+1)'(r2_wx); pb = (DW+1)'(r2_vx); end
            else begin pa = (DW+1)'(r2_wy); pb = (DW+1)'(r2_vy); end
            pl = '0; ph = '0;
            col_hit = (pb >= 0) ? (pa >= 0 && pa <= pb) : (pa <= 0 && pa >= pb);
        end else if (vpt) begin
            // p on a-b: -w between 0 and u
            if (r2_ux != '0) begin pa = -(DW+1)'(r2_wx); pb = (DW+1)'(r2_ux); end
            else begin pa = -(DW+1)'(r2_wy); pb = (DW+1)'(r2_uy); end
            pl = '0; ph = '0;
            col_hit = (pb >= 0) ? (pa >= 0 && pa <= pb) : (pa <= 0 && pa >= pb);
        end else begin
            pa = '0; pb = '0; pl = lo; ph = hi;
            col_hit = (pl <= s) && (ph >= 0);
        end
        if (d < 0) begin
            dn = -d; nun = -nu; nvn = -nv;
        end else begin
            dn = d; nun = nu; nvn = nv;
        end
        gen_hit = (nvn >= 0) && (nvn <= dn) && (nun >= 0) && (nun <= dn);
        if (d == '0)
            n_hit = (nu == '0) && (nv == '0) && col_hit;
        else
            n_hit = gen_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            o_hit <= n_hit;
    end

endmodule

>>> rtl/segment_rectangle_intersect_test_unit.sv
// ----------------------------------------------------------------------------
// segment_rectangle_intersect_test_unit: segment vs rectangle hit test
// Sorts the rectangle corners, runs four pipelined edge tests plus a
// midpoint containment test, and ORs the results into one hit bit.
// ----------------------------------------------------------------------------
// Usage: present a segment and two opposite rectangle corners on the input
// channel (i_valid/o_ready); one hit bit per query returns on the output
// channel (o_valid/i_ready), in order.
// Throughput: one query per cycle while the receiver takes results.
// Pipeline: five register stages (corner sort, the edge tests' difference,
// product and decision registers, OR), the first loaded by the input
// transfer itself; the depth is set by the product and compare.
// The whole pipeline advances as one unit; when the receiver stalls with a
// result waiting, every stage holds and o_ready falls only if the output
// stage is full, so no bubble in the pipe blocks intake.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_test_unit
    import srit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_seg_x0,
    input  logic signed [COORD_BITS-1:0] i_seg_y0,
    input  logic signed [COORD_BITS-1:0] i_seg_x1,
    input  logic signed [COORD_BITS-1:0] i_seg_y1,
    input  logic signed [COORD_BITS-1:0] i_rect_xa,
    input  logic signed [COORD_BITS-1:0] i_rect_ya,
    input  logic signed [COORD_BITS-1:0] i_rect_xb,
    input  logic signed [COORD_BITS-1:0] i_rect_yb,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit
);

    localparam int STAGES = 5;
    localparam int MW     = COORD_BITS + 1;

    logic [STAGES-1:0] r_vld;
    logic              en;

    // advance unless the output holds an untaken result
    assign en      = !(r_vld[STAGES-1] && !i_ready);
    assign o_ready = en;
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (en)
            r_vld <= {r_vld[STAGES-2:0], i_valid};
    end

    // stage 0: sort corners, form doubled midpoint
    logic signed [COORD_BITS-1:0] r_x0, r_y0, r_x1, r_y1, r_xlo, r_xhi, r_ylo, r_yhi;
    logic signed [MW-1:0]         r_mx, r_my;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0  <= i_seg_x0; r_y0 <= i_seg_y0;
            r_x1  <= i_seg_x1; r_y1 <= i_seg_y1;
            r_xlo <= (i_rect_xa < i_rect_xb) ? i_rect_xa : i_rect_xb;
            r_xhi <= (i_rect_xa < i_rect_xb) ? i_rect_xb : i_rect_xa;
            r_ylo <= (i_rect_ya < i_rect_yb) ? i_rect_ya : i_rect_yb;
            r_yhi <= (i_rect_ya < i_rect_yb) ? i_rect_yb : i_rect_ya;
            r_mx  <= MW'(i_seg_x0) + MW'(i_seg_x1);
            r_my  <= MW'(i_seg_y0) + MW'(i_seg_y1);
        end
    end

    logic [NUM_EDGES-1:0] edge_hit;

    srit_edge #(.COORD_BITS(COORD_BITS)) u_e0 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(r_x0), .i_ay(r_y0), .i_bx(r_x1), .i_by(r_y1),
        .i_px(r_xlo), .i_py(r_ylo), .i_qx(r_xhi), .i_qy(r_ylo), .o_hit(edge_hit[0]));
    srit_edge #(.COORD_BITS(COORD_BITS)) u_e1 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(r_x0), .i_ay(r_y0), .i_bx(r_x1), .i_by(r_y1),
        .i_px(r_xlo), .i_py(r_ylo), .i_qx(r_xlo), .i_qy(r_yhi), .o_hit(edge_hit[1]));
    srit_edge #(.COORD_BITS(COORD_BITS)) u_e2 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(r_x0), .i_ay(r_y0), .i_bx(r_x1), .i_by(r_y1),
        .i_px(r_xhi), .i_py(r_yhi), .i_qx(r_xlo), .i_qy(r_yhi), .o_hit(edge_hit[2]));
    srit_edge #(.COORD_BITS(COORD_BITS)) u_e3 (
        .i_clk(i_clk), .i_en(en),
        .i_ax(r_x0), .i_ay(r_y0), .i_bx(r_x1), .i_by(r_y1),
        .i_px(r_xhi), .i_py(r_yhi), .i_qx(r_xhi), .i_qy(r_ylo), .o_hit(edge_hit[3]));

    // midpoint containment, delayed to line up with the edge results
    logic [2:0] r_in;
    logic       n_in;

    assign n_in = (r_mx >= $signed({r_xlo, 1'b0})) && (r_mx <= $signed({r_xhi, 1'b0}))
               && (r_my >= $signed({r_ylo, 1'b0})) && (r_my <= $signed({r_yhi, 1'b0}));

    always_ff @(posedge i_clk) begin
        if (en)
            r_in <= {r_in[1:0], n_in};
    end

    always_ff @(posedge i_clk) begin
        if (en)
            o_hit <= (|edge_hit) | r_in[2];
    end

endmodule
